// ===== src/mf3_pkg.sv =====
// Package for the 3x3 RGB median filter: pixel and window types, register map,
// frame size limits. No dependencies; imported by every module of the filter.
package mf3_pkg;

    localparam int MAX_WIDTH = 128;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 12;
    localparam int CHAN_W    = 8;
    localparam int FW_W      = 8;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam int WIN_N     = 9;

    localparam logic [FW_W-1:0]  MIN_WIDTH_V  = 8'd3;
    localparam logic [FW_W-1:0]  MAX_WIDTH_V  = FW_W'(MAX_WIDTH);
    localparam logic [ROW_W-1:0] MIN_HEIGHT_V = 12'd3;
    localparam logic [FW_W-1:0]  RST_WIDTH    = 8'd62;
    localparam logic [ROW_W-1:0] RST_HEIGHT   = 12'd94;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [ROW_W-1:0]  row_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } pix_t;

    typedef struct packed {
        pix_t mid;
        pix_t top;
    } line_t;

    typedef logic [WIN_N-1:0][CHAN_W-1:0] win9_t;

endpackage

// ===== src/mf3_line_buf.sv =====
// Line buffer of the 3x3 median filter: two image rows per column address.
// Depends on mf3_pkg.
module mf3_line_buf (
    input  logic          clk,
    input  logic          rd_en,
    input  mf3_pkg::col_t rd_addr,
    output mf3_pkg::line_t rd_data,
    input  logic          wr_en,
    input  mf3_pkg::col_t wr_addr,
    input  mf3_pkg::line_t wr_data
);
    import mf3_pkg::*;

    line_t mem [MAX_WIDTH];
    line_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/mf3_median9.sv =====
// Nine-input median of one color channel by a fixed compare-exchange network.
// Depends on mf3_pkg.
module mf3_median9 (
    input  mf3_pkg::win9_t win,
    output mf3_pkg::chan_t med
);
    import mf3_pkg::*;

    function automatic logic [2*CHAN_W-1:0] cas(chan_t a, chan_t b);
        if (a > b)
        begin
            return {a, b};
        end
        return {b, a};
    endfunction

    chan_t p [WIN_N];

    always_comb
    begin
        for (int i = 0; i < WIN_N; i++)
        begin
            p[i] = win[i];
        end
        {p[2], p[1]} = cas(p[1], p[2]);
        {p[5], p[4]} = cas(p[4], p[5]);
        {p[8], p[7]} = cas(p[7], p[8]);
        {p[1], p[0]} = cas(p[0], p[1]);
        {p[4], p[3]} = cas(p[3], p[4]);
        {p[7], p[6]} = cas(p[6], p[7]);
        {p[2], p[1]} = cas(p[1], p[2]);
        {p[5], p[4]} = cas(p[4], p[5]);
        {p[8], p[7]} = cas(p[7], p[8]);
        {p[3], p[0]} = cas(p[0], p[3]);
        {p[8], p[5]} = cas(p[5], p[8]);
        {p[7], p[4]} = cas(p[4], p[7]);
        {p[6], p[3]} = cas(p[3], p[6]);
        {p[4], p[1]} = cas(p[1], p[4]);
        {p[5], p[2]} = cas(p[2], p[5]);
        {p[7], p[4]} = cas(p[4], p[7]);
        {p[2], p[4]} = cas(p[4], p[2]);
        {p[4], p[6]} = cas(p[6], p[4]);
        {p[2], p[4]} = cas(p[4], p[2]);
        med = p[4];
    end

endmodule

// ===== src/median_filter_3x3_rgb_top.sv =====
// Top level of the 3x3 RGB median filter: APB registers, counters, window, output register.
// Depends on mf3_pkg, mf3_line_buf and mf3_median9.
//
// Usage:
// Pixels enter in raster order on the in_valid/in_ready channel (blue, green, red),
// frame_width pixels per row and frame_height rows per frame. For each pixel that
// completes a full 3x3 window (column >= 2, row >= 2) one result leaves on the
// out_valid/out_ready channel: per-channel medians plus the window center's column
// and row; frame_last marks the result centered at (width-2, height-2). Border pixels
// produce no result.
// Path: an input transfer loads the stage register and starts the line-buffer read; when the
// stage advances, the result register loads the medians. Throughput: one pixel per cycle
// while the receiver does not stall the result register, set by the single-port-read line
// buffer and the one-pass sorting networks.
// When the receiver stalls, the result register holds; pixels keep entering until one
// that completes a window waits in the stage register, after which in_ready drops
// until the result is taken.
// Reset: frame_width 62, frame_height 94, counters and window at zero. Line buffer
// contents are undefined; the first two rows of a frame refill them.
// Writing a register over APB (at 4*index) restarts the frame at column and row zero.
module median_filter_3x3_rgb_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mf3_pkg::ADDR_W-1:0]  paddr,
    input  logic [mf3_pkg::DATA_W-1:0]  pwdata,
    output logic [mf3_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  mf3_pkg::chan_t              blue,
    input  mf3_pkg::chan_t              green,
    input  mf3_pkg::chan_t              red,
    output logic                        out_valid,
    input  logic                        out_ready,
    output mf3_pkg::chan_t              med_blue,
    output mf3_pkg::chan_t              med_green,
    output mf3_pkg::chan_t              med_red,
    output mf3_pkg::col_t               center_col,
    output mf3_pkg::row_t               center_row,
    output logic                        frame_last
);
    import mf3_pkg::*;

    logic [FW_W-1:0] width_reg;
    row_t            height_reg;
    col_t            col_reg;
    row_t            row_reg;
    col_t            col_next;
    row_t            row_next;

    logic            cfg_wr;
    logic            in_fire;
    logic [FW_W-1:0] w_eff;
    logic [FW_W-1:0] w_m1;
    col_t            last_col;
    row_t            h_eff;
    row_t            last_row;
    col_t            col_eff;
    logic            produce;

    logic            s1_valid_reg;
    logic            s1_produce_reg;
    logic            s1_last_reg;
    pix_t            s1_cur_reg;
    col_t            s1_col_reg;
    col_t            s1_ccol_reg;
    row_t            s1_crow_reg;
    logic            s1_advance;

    pix_t            win_reg [6];
    line_t           rd_line;
    line_t           wr_line;
    pix_t            full_win [WIN_N];
    win9_t           win_b;
    win9_t           win_g;
    win9_t           win_r;
    chan_t           m_b;
    chan_t           m_g;
    chan_t           m_r;

    logic            out_valid_reg;
    logic            out_valid_next;
    chan_t           med_blue_reg;
    chan_t           med_green_reg;
    chan_t           med_red_reg;
    col_t            ccol_reg;
    row_t            crow_reg;
    logic            last_reg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign in_fire = in_valid && in_ready;

    always_comb
    begin
        case (paddr[2])
            REG_FRAME_WIDTH:  prdata = DATA_W'(width_reg);
            REG_FRAME_HEIGHT: prdata = DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_FRAME_WIDTH:  width_reg  <= pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= pwdata[ROW_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg < MIN_WIDTH_V)
        begin
            w_eff = MIN_WIDTH_V;
        end
        else if (width_reg > MAX_WIDTH_V)
        begin
            w_eff = MAX_WIDTH_V;
        end
        else
        begin
            w_eff = width_reg;
        end
        w_m1     = w_eff - 8'd1;
        last_col = w_m1[COL_W-1:0];
        h_eff    = (height_reg < MIN_HEIGHT_V) ? MIN_HEIGHT_V : height_reg;
        last_row = h_eff - 12'd1;
        col_eff  = ({1'b0, col_reg} >= w_eff) ? '0 : col_reg;
        produce  = (col_eff >= COL_W'(2)) && (row_reg >= 12'd2);
        if (col_eff >= last_col)
        begin
            col_next = '0;
            row_next = (row_reg >= last_row) ? '0 : row_reg + 12'd1;
        end
        else
        begin
            col_next = col_eff + COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_wr)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign s1_advance = s1_valid_reg && (!s1_produce_reg || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cur_reg     <= '{red: red, green: green, blue: blue};
            s1_col_reg     <= col_eff;
            s1_produce_reg <= produce;
            s1_ccol_reg    <= col_eff - COL_W'(1);
            s1_crow_reg    <= row_reg - 12'd1;
            s1_last_reg    <= (col_eff == last_col) && (row_reg == last_row);
        end
    end

    assign wr_line = '{mid: s1_cur_reg, top: rd_line.mid};

    mf3_line_buf u_line_buf (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (col_eff),
        .rd_data (rd_line),
        .wr_en   (s1_advance),
        .wr_addr (s1_col_reg),
        .wr_data (wr_line)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_advance)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= rd_line.top;
            win_reg[4] <= rd_line.mid;
            win_reg[5] <= s1_cur_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            full_win[i] = win_reg[i];
        end
        full_win[6] = rd_line.top;
        full_win[7] = rd_line.mid;
        full_win[8] = s1_cur_reg;
        for (int i = 0; i < WIN_N; i++)
        begin
            win_b[i] = full_win[i].blue;
            win_g[i] = full_win[i].green;
            win_r[i] = full_win[i].red;
        end
    end

    mf3_median9 u_med_blue  (.win(win_b), .med(m_b));
    mf3_median9 u_med_green (.win(win_g), .med(m_g));
    mf3_median9 u_med_red   (.win(win_r), .med(m_r));

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_advance && s1_produce_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_produce_reg)
        begin
            med_blue_reg  <= m_b;
            med_green_reg <= m_g;
            med_red_reg   <= m_r;
            ccol_reg      <= s1_ccol_reg;
            crow_reg      <= s1_crow_reg;
            last_reg      <= s1_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign med_blue   = med_blue_reg;
    assign med_green  = med_green_reg;
    assign med_red    = med_red_reg;
    assign center_col = ccol_reg;
    assign center_row = crow_reg;
    assign frame_last = last_reg;

    a_fire_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("accepted pixel did not reach the stage register");

    a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (col_reg == '0) && (row_reg == '0))
        else $error("register write did not restart the frame");

    a_center_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (ccol_reg != '0) && (crow_reg != '0))
        else $error("result centered on a border pixel");

    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> (crow_reg == h_eff - 12'd2))
        else $error("frame_last on a result outside the last interior row");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for median_filter_3x3_rgb_top: raster pixel frames in, 3x3 medians out.
// Depends on mf3_pkg and the filter RTL; a window model predicts results not fixed by the table.
module tb;
    import mf3_pkg::*;

    typedef struct packed {
        chan_t blue;
        chan_t green;
        chan_t red;
        col_t  col;
        row_t  row;
        logic  last;
    } med_result_t;

    typedef struct packed {
        logic        fixed;
        pix_t        px;
        med_result_t res;
    } dir_row_t;

    typedef struct packed {
        logic [FW_W-1:0]  w;
        logic [ROW_W-1:0] h;
        logic [15:0]      n;
    } frame_plan_t;

    localparam logic [ADDR_W-1:0] WIDTH_ADDR  = {REG_FRAME_WIDTH, 2'b00};
    localparam logic [ADDR_W-1:0] HEIGHT_ADDR = {REG_FRAME_HEIGHT, 2'b00};
    localparam med_result_t NO_RES = '0;
    localparam int DIR_N  = 18;
    localparam int PLAN_N = 6;
    localparam int ITEM_GOAL = 1650;

    localparam dir_row_t DIR_TAB [DIR_N] = '{
        {1'b0, 24'hFF0000, NO_RES},
        {1'b0, 24'hFFFF01, NO_RES},
        {1'b0, 24'hFF0002, NO_RES},
        {1'b0, 24'hFFFF03, NO_RES},
        {1'b0, 24'hFF0004, NO_RES},
        {1'b0, 24'hFFFF05, NO_RES},
        {1'b0, 24'hFF0006, NO_RES},
        {1'b0, 24'hFFFF07, NO_RES},
        {1'b1, 24'hFF0008, {8'h04, 8'h00, 8'hFF, 7'd1, 12'd1, 1'b1}},
        {1'b0, 24'h00807F, NO_RES},
        {1'b0, 24'hFF7F80, NO_RES},
        {1'b0, 24'h01FE00, NO_RES},
        {1'b0, 24'hFE01FF, NO_RES},
        {1'b0, 24'h55AA33, NO_RES},
        {1'b0, 24'hAA55CC, NO_RES},
        {1'b0, 24'h33CC0F, NO_RES},
        {1'b0, 24'hCC33F0, NO_RES},
        {1'b0, 24'h0FF055, NO_RES}
    };

    localparam frame_plan_t EDGE_PLANS [PLAN_N] = '{
        {8'd255, 12'd2,    16'd384},
        {8'd2,   12'd4095, 16'd120},
        {8'd128, 12'd3,    16'd200},
        {8'd3,   12'd3,    16'd36},
        {8'd62,  12'd94,   16'd200},
        {8'd129, 12'd0,    16'd130}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_ready;
    chan_t             blue = '0;
    chan_t             green = '0;
    chan_t             red = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    chan_t             med_blue;
    chan_t             med_green;
    chan_t             med_red;
    col_t              center_col;
    row_t              center_row;
    logic              frame_last;

    logic              fixed_valid = 1'b0;
    med_result_t       fixed_res = '0;

    pix_t              line_mem [2*MAX_WIDTH];
    pix_t              win_q [6];
    int unsigned       col_cnt = 0;
    int unsigned       row_cnt = 0;
    logic [FW_W-1:0]   width_reg = 8'd62;
    logic [ROW_W-1:0]  height_reg = 12'd94;

    med_result_t       expected_medians [$];
    med_result_t       pred_res;
    med_result_t       got_res;
    int unsigned       mismatch_count = 0;
    int unsigned       pixels_sent = 0;

    median_filter_3x3_rgb_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .blue       (blue),
        .green      (green),
        .red        (red),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .med_blue   (med_blue),
        .med_green  (med_green),
        .med_red    (med_red),
        .center_col (center_col),
        .center_row (center_row),
        .frame_last (frame_last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < 2*MAX_WIDTH; i++)
        begin
            line_mem[i] = '0;
        end
        for (int i = 0; i < 6; i++)
        begin
            win_q[i] = '0;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < 40)
        begin
            $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    function automatic int unsigned eff_width(input logic [FW_W-1:0] raw);
        if (raw < MIN_WIDTH_V)
        begin
            return 32'(MIN_WIDTH_V);
        end
        if (raw > MAX_WIDTH_V)
        begin
            return 32'(MAX_WIDTH_V);
        end
        return 32'(raw);
    endfunction

    function automatic int unsigned eff_height(input logic [ROW_W-1:0] raw);
        return (raw < MIN_HEIGHT_V) ? 32'(MIN_HEIGHT_V) : 32'(raw);
    endfunction

    function automatic chan_t med9(input win9_t v);
        int lo;
        int eq;
        for (int i = 0; i < WIN_N; i++)
        begin
            lo = 0;
            eq = 0;
            for (int j = 0; j < WIN_N; j++)
            begin
                if (v[j] < v[i])
                begin
                    lo++;
                end
                else if (v[j] == v[i])
                begin
                    eq++;
                end
            end
            if (lo <= WIN_N / 2 && lo + eq > WIN_N / 2)
            begin
                return v[i];
            end
        end
        return '0;
    endfunction

    // Advance the window model by one pixel; return 1 when a full window completes.
    function automatic bit filter_pixel(input pix_t cur, output med_result_t res);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        pix_t        top;
        pix_t        mid;
        pix_t        win [WIN_N];
        win9_t       bv;
        win9_t       gv;
        win9_t       rv;
        bit          hit;
        w = eff_width(width_reg);
        h = eff_height(height_reg);
        c = col_cnt;
        r = row_cnt;
        top = line_mem[c];
        mid = line_mem[MAX_WIDTH + c];
        for (int i = 0; i < 6; i++)
        begin
            win[i] = win_q[i];
        end
        win[6] = top;
        win[7] = mid;
        win[8] = cur;
        for (int i = 0; i < WIN_N; i++)
        begin
            bv[i] = win[i].blue;
            gv[i] = win[i].green;
            rv[i] = win[i].red;
        end
        hit = (c >= 2) && (r >= 2);
        res = '0;
        if (hit)
        begin
            res.blue  = med9(bv);
            res.green = med9(gv);
            res.red   = med9(rv);
            res.col   = col_t'(c - 1);
            res.row   = row_t'(r - 1);
            res.last  = (c == w - 1) && (r == h - 1);
        end
        win_q[0] = win_q[3];
        win_q[1] = win_q[4];
        win_q[2] = win_q[5];
        win_q[3] = top;
        win_q[4] = mid;
        win_q[5] = cur;
        line_mem[c] = mid;
        line_mem[MAX_WIDTH + c] = cur;
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
            begin
                r = 0;
            end
        end
        col_cnt = c;
        row_cnt = r;
        return hit;
    endfunction

    function automatic chan_t rand_chan();
        case ($urandom_range(0, 5))
            0: return chan_t'($urandom_range(0, 3));
            1: return chan_t'($urandom_range(252, 255));
            default: return chan_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int rand_gap(input bit steady);
        int pick;
        pick = $urandom_range(0, 99);
        if (steady || pick < 65)
        begin
            return 0;
        end
        if (pick < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (pick < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    task automatic reg_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write both frame registers, read them back, restart the model's frame.
    task automatic set_frame(input logic [FW_W-1:0] w, input logic [ROW_W-1:0] h);
        logic [DATA_W-1:0] wd;
        logic [DATA_W-1:0] rd;
        wd = $urandom;
        wd[FW_W-1:0] = w;
        reg_access(1'b1, WIDTH_ADDR, wd, rd);
        width_reg = w;
        col_cnt = 0;
        row_cnt = 0;
        reg_access(1'b0, WIDTH_ADDR, '0, rd);
        if (rd[FW_W-1:0] !== w)
        begin
            report_mismatch("frame_width readback", rd[FW_W-1:0], w);
        end
        wd = $urandom;
        wd[ROW_W-1:0] = h;
        reg_access(1'b1, HEIGHT_ADDR, wd, rd);
        height_reg = h;
        col_cnt = 0;
        row_cnt = 0;
        reg_access(1'b0, HEIGHT_ADDR, '0, rd);
        if (rd[ROW_W-1:0] !== h)
        begin
            report_mismatch("frame_height readback", rd[ROW_W-1:0], h);
        end
    endtask

    task automatic send_pixel(input pix_t px, input logic fixed, input med_result_t res,
                              input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        red         <= px.red;
        green       <= px.green;
        blue        <= px.blue;
        fixed_valid <= fixed;
        fixed_res   <= res;
        do @(posedge clk); while (!in_ready);
        pixels_sent++;
    endtask

    // Let the block settle: no result pending, and any border pixel through the pipe.
    task automatic wait_idle();
        do @(posedge clk); while (expected_medians.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic run_frames(input frame_plan_t plan);
        bit steady;
        pix_t px;
        steady = ($urandom_range(0, 3) == 0);
        set_frame(plan.w, plan.h);
        for (int i = 0; i < plan.n; i++)
        begin
            px.red   = rand_chan();
            px.green = rand_chan();
            px.blue  = rand_chan();
            send_pixel(px, 1'b0, NO_RES, rand_gap(steady));
        end
        in_valid <= 1'b0;
        wait_idle();
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                if (filter_pixel({red, green, blue}, pred_res) || fixed_valid)
                begin
                    expected_medians.push_back(fixed_valid ? fixed_res : pred_res);
                end
            end
            if (out_valid && out_ready)
            begin
                if (expected_medians.size() == 0)
                begin
                    report_mismatch("result with none pending", center_col, 0);
                end
                else
                begin
                    got_res = expected_medians.pop_front();
                    if (med_blue !== got_res.blue)
                    begin
                        report_mismatch("med_blue", med_blue, got_res.blue);
                    end
                    if (med_green !== got_res.green)
                    begin
                        report_mismatch("med_green", med_green, got_res.green);
                    end
                    if (med_red !== got_res.red)
                    begin
                        report_mismatch("med_red", med_red, got_res.red);
                    end
                    if (center_col !== got_res.col)
                    begin
                        report_mismatch("center_col", center_col, got_res.col);
                    end
                    if (center_row !== got_res.row)
                    begin
                        report_mismatch("center_row", center_row, got_res.row);
                    end
                    if (frame_last !== got_res.last)
                    begin
                        report_mismatch("frame_last", frame_last, got_res.last);
                    end
                end
            end
        end
    end

    initial
    begin
        int run;
        int stall;
        int pick;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 6);
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                stall = 0;
            end
            else if (pick < 88)
            begin
                stall = $urandom_range(1, 3);
            end
            else if (pick < 97)
            begin
                stall = $urandom_range(4, 15);
            end
            else
            begin
                stall = $urandom_range(30, 60);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial
    begin
        logic [DATA_W-1:0] rd;
        frame_plan_t plan;
        int unsigned ew;
        int unsigned eh;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        reg_access(1'b0, WIDTH_ADDR, '0, rd);
        if (rd[FW_W-1:0] !== 8'd62)
        begin
            report_mismatch("frame_width after reset", rd[FW_W-1:0], 8'd62);
        end
        reg_access(1'b0, HEIGHT_ADDR, '0, rd);
        if (rd[ROW_W-1:0] !== 12'd94)
        begin
            report_mismatch("frame_height after reset", rd[ROW_W-1:0], 12'd94);
        end

        // Two back-to-back 3x3 frames, both sizes written below range.
        set_frame(8'd0, 12'd1);
        for (int i = 0; i < DIR_N; i++)
        begin
            send_pixel(DIR_TAB[i].px, DIR_TAB[i].fixed, DIR_TAB[i].res, rand_gap(1'b0));
        end
        in_valid <= 1'b0;
        wait_idle();

        for (int i = 0; i < PLAN_N; i++)
        begin
            run_frames(EDGE_PLANS[i]);
        end

        while (pixels_sent < ITEM_GOAL)
        begin
            plan.w = ($urandom_range(0, 4) == 0) ? FW_W'($urandom_range(0, 255))
                                                 : FW_W'($urandom_range(3, 16));
            plan.h = ($urandom_range(0, 4) == 0) ? ROW_W'($urandom_range(0, 4095))
                                                 : ROW_W'($urandom_range(3, 6));
            ew = eff_width(plan.w);
            eh = eff_height(plan.h);
            if (ew * eh * 3 > 400)
            begin
                plan.n = 16'($urandom_range(50, 400));
            end
            else
            begin
                plan.n = 16'($urandom_range(1, 3) * ew * eh + $urandom_range(0, 2 * ew));
            end
            run_frames(plan);
        end

        wait_idle();
        if (mismatch_count == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mf3_pkg.sv
src/mf3_line_buf.sv
src/mf3_median9.sv
src/median_filter_3x3_rgb_top.sv
tb/tb.sv
